>>> rtl/rhsp_pkg.sv
// ----------------------------------------------------------------------------
// rhsp_pkg
// Shared types, constants and command/status records for the string period
// finder.
// ----------------------------------------------------------------------------
package rhsp_pkg;

    localparam int HASH_W     = 30;
    localparam int NUM_LANES  = 3;
    localparam int STEP_W     = 5;
    localparam int CODE_W     = 7;
    localparam int PERIOD_W   = 13;

    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [STEP_W-1:0] step_t;

    localparam hash_t MODULI [0:NUM_LANES-1] = '{30'd1000000007, 30'd1000000003, 30'd998244353};

    localparam int    BASE_STEPS   = 9;
    localparam hash_t BASE_ALIGNED = hash_t'(311) << (HASH_W - BASE_STEPS);
    localparam step_t STEPS_BASE   = step_t'(BASE_STEPS);
    localparam step_t STEPS_FULL   = step_t'(HASH_W);

    localparam logic [1:0] RD_LO1 = 2'd0;
    localparam logic [1:0] RD_HI  = 2'd1;
    localparam logic [1:0] RD_LEN = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       load_mul;
        logic       load_write;
        logic       mark_ovf;
        logic       search_init;
        logic [1:0] rd_sel;
        logic       seg_mul;
        logic       cap_hi;
        logic       cap_len;
        logic       seg_adv;
        logic       next_p;
        logic       out_load;
    } rhsp_cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic full;
        logic last;
        logic seg_match;
        logic seg_final;
        logic out_free;
    } rhsp_status_t;

endpackage

>>> rtl/rhsp_modmul.sv
// ----------------------------------------------------------------------------
// rhsp_modmul
// Bit-serial modular multiplier: one bit of b per cycle, msb first, with the
// running sum kept below the modulus.
// ----------------------------------------------------------------------------
module rhsp_modmul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  rhsp_pkg::hash_t a,
    input  rhsp_pkg::hash_t b,
    input  rhsp_pkg::step_t steps,
    input  rhsp_pkg::hash_t modulus,
    output logic            busy,
    output rhsp_pkg::hash_t result
);

    localparam int SUM_W = rhsp_pkg::HASH_W + 2;

    logic            busy_reg, busy_next;
    rhsp_pkg::step_t cnt_reg, cnt_next;
    rhsp_pkg::hash_t acc_reg, acc_next;
    rhsp_pkg::hash_t a_reg, a_next;
    rhsp_pkg::hash_t b_reg, b_next;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] mod1;
    logic [SUM_W-1:0] mod2;
    logic [SUM_W-1:0] red;

    always_comb
    begin
        mod1 = SUM_W'(modulus);
        mod2 = mod1 << 1;
        sum  = (SUM_W'(acc_reg) << 1) + (b_reg[rhsp_pkg::HASH_W-1] ? SUM_W'(a_reg) : '0);
        priority if (sum >= mod2)
        begin
            red = sum - mod2;
        end
        else if (sum >= mod1)
        begin
            red = sum - mod1;
        end
        else
        begin
            red = sum;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        priority if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
        end
        else if (busy_reg)
        begin
            acc_next  = red[rhsp_pkg::HASH_W-1:0];
            b_next    = b_reg << 1;
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != rhsp_pkg::step_t'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign busy   = busy_reg;
    assign result = acc_reg;

endmodule

>>> rtl/rhsp_ctrl.sv
// ----------------------------------------------------------------------------
// rhsp_ctrl
// Sequencer for loading characters and for the period search.
// ----------------------------------------------------------------------------
module rhsp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  rhsp_pkg::rhsp_status_t status,
    output rhsp_pkg::rhsp_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_LOAD_CHK = 4'd1;
    localparam logic [3:0] ST_LOAD_WT  = 4'd2;
    localparam logic [3:0] ST_SRCH     = 4'd3;
    localparam logic [3:0] ST_RD_LO    = 4'd4;
    localparam logic [3:0] ST_RD_HI    = 4'd5;
    localparam logic [3:0] ST_RD_LEN   = 4'd6;
    localparam logic [3:0] ST_CAP_LEN  = 4'd7;
    localparam logic [3:0] ST_MUL_WT   = 4'd8;
    localparam logic [3:0] ST_EVAL     = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = rhsp_pkg::RD_LO1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD_CHK;
                end
            end
            ST_LOAD_CHK:
            begin
                if (status.full)
                begin
                    cmd.mark_ovf = 1'b1;
                    state_next   = status.last ? ST_SRCH : ST_IDLE;
                end
                else
                begin
                    cmd.load_mul = 1'b1;
                    state_next   = ST_LOAD_WT;
                end
            end
            ST_LOAD_WT:
            begin
                if (!status.mul_busy)
                begin
                    cmd.load_write = 1'b1;
                    state_next     = status.last ? ST_SRCH : ST_IDLE;
                end
            end
            ST_SRCH:
            begin
                cmd.search_init = 1'b1;
                state_next      = ST_RD_LO;
            end
            ST_RD_LO:
            begin
                cmd.rd_sel = rhsp_pkg::RD_LO1;
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                cmd.rd_sel  = rhsp_pkg::RD_HI;
                cmd.seg_mul = 1'b1;
                state_next  = ST_RD_LEN;
            end
            ST_RD_LEN:
            begin
                cmd.rd_sel = rhsp_pkg::RD_LEN;
                cmd.cap_hi = 1'b1;
                state_next = ST_CAP_LEN;
            end
            ST_CAP_LEN:
            begin
                cmd.cap_len = 1'b1;
                state_next  = ST_MUL_WT;
            end
            ST_MUL_WT:
            begin
                if (!status.mul_busy)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                priority if (!status.seg_match)
                begin
                    cmd.next_p = 1'b1;
                    state_next = ST_RD_LO;
                end
                else if (status.seg_final)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.seg_adv = 1'b1;
                    state_next  = ST_RD_LO;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

>>> rtl/rhsp_datapath.sv
// ----------------------------------------------------------------------------
// rhsp_datapath
// Prefix hash and power memories, modular multipliers, search counters and
// the result register.
// ----------------------------------------------------------------------------
module rhsp_datapath #(
    parameter int MAX_LEN = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rhsp_pkg::rhsp_cmd_t               cmd,
    output rhsp_pkg::rhsp_status_t            status,
    input  logic [rhsp_pkg::CODE_W-1:0]       char_code,
    input  logic                              last,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [rhsp_pkg::PERIOD_W-1:0]     period,
    output logic                              too_long
);

    localparam int DEPTH = MAX_LEN + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;
    localparam int NL    = rhsp_pkg::NUM_LANES;

    logic [CW-1:0]               count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic [rhsp_pkg::CODE_W-1:0] code_reg;
    logic                        last_reg;
    logic [CW-1:0]               p_reg, p_next;
    logic [CW-1:0]               lo_reg, lo_next;
    logic                        out_valid_reg, out_valid_next;
    logic [rhsp_pkg::PERIOD_W-1:0] period_reg;
    logic                        too_long_reg;
    logic                        rd_zero_reg;

    logic [CW-1:0] rem;
    logic [CW-1:0] hi;
    logic [CW-1:0] len;
    logic [CW-1:0] rd_full;
    logic [CW-1:0] waddr_full;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] pw_addr;
    logic [AW-1:0] waddr;

    logic [NL-1:0] lane_match;
    logic [NL-1:0] lane_busy_h;
    logic [NL-1:0] lane_busy_p;

    always_comb
    begin
        rem        = count_reg - lo_reg + 1'b1;
        hi         = (rem > p_reg) ? (lo_reg + p_reg - 1'b1) : count_reg;
        len        = hi - lo_reg + 1'b1;
        waddr_full = count_reg + 1'b1;
        unique case (cmd.rd_sel)
            rhsp_pkg::RD_LO1: rd_full = lo_reg - 1'b1;
            rhsp_pkg::RD_HI:  rd_full = hi;
            rhsp_pkg::RD_LEN: rd_full = len;
            default:          rd_full = '0;
        endcase
    end

    assign rd_addr = rd_full[AW-1:0];
    assign pw_addr = len[AW-1:0];
    assign waddr   = waddr_full[AW-1:0];

    genvar k;
    generate
        for (k = 0; k < NL; k++)
        begin : g_lane
            rhsp_pkg::hash_t hash_mem [0:DEPTH-1];
            rhsp_pkg::hash_t pow_mem  [0:DEPTH-1];
            rhsp_pkg::hash_t hash_rd_reg;
            rhsp_pkg::hash_t pow_rd_reg;
            rhsp_pkg::hash_t cur_h_reg, cur_h_next;
            rhsp_pkg::hash_t cur_p_reg, cur_p_next;
            rhsp_pkg::hash_t hold_hi_reg;
            rhsp_pkg::hash_t hold_len_reg;
            rhsp_pkg::hash_t hash_adj;
            rhsp_pkg::hash_t mul_h_a;
            rhsp_pkg::hash_t mul_h_b;
            rhsp_pkg::step_t mul_h_steps;
            rhsp_pkg::hash_t mul_h_res;
            rhsp_pkg::hash_t mul_p_res;
            rhsp_pkg::hash_t new_h;
            rhsp_pkg::hash_t seg;
            logic [rhsp_pkg::HASH_W:0] add_sum;
            logic [rhsp_pkg::HASH_W:0] seg_sum;
            logic [rhsp_pkg::HASH_W:0] mod_ext;

            assign hash_adj    = rd_zero_reg ? '0 : hash_rd_reg;
            assign mul_h_a     = cmd.load_mul ? cur_h_reg : hash_adj;
            assign mul_h_b     = cmd.load_mul ? rhsp_pkg::BASE_ALIGNED : pow_rd_reg;
            assign mul_h_steps = cmd.load_mul ? rhsp_pkg::STEPS_BASE : rhsp_pkg::STEPS_FULL;

            rhsp_modmul u_hmul (
                .clk     (clk),
                .rst_n   (rst_n),
                .start   (cmd.load_mul | cmd.seg_mul),
                .a       (mul_h_a),
                .b       (mul_h_b),
                .steps   (mul_h_steps),
                .modulus (rhsp_pkg::MODULI[k]),
                .busy    (lane_busy_h[k]),
                .result  (mul_h_res)
            );

            rhsp_modmul u_pmul (
                .clk     (clk),
                .rst_n   (rst_n),
                .start   (cmd.load_mul),
                .a       (cur_p_reg),
                .b       (rhsp_pkg::BASE_ALIGNED),
                .steps   (rhsp_pkg::STEPS_BASE),
                .modulus (rhsp_pkg::MODULI[k]),
                .busy    (lane_busy_p[k]),
                .result  (mul_p_res)
            );

            assign lane_match[k] = (seg == hold_len_reg);

            always_comb
            begin
                mod_ext = {1'b0, rhsp_pkg::MODULI[k]};
                add_sum = {1'b0, mul_h_res} + (rhsp_pkg::HASH_W+1)'(code_reg);
                new_h   = (add_sum >= mod_ext) ? rhsp_pkg::hash_t'(add_sum - mod_ext)
                                               : rhsp_pkg::hash_t'(add_sum);
                seg_sum = {1'b0, hold_hi_reg} + mod_ext - {1'b0, mul_h_res};
                seg     = (seg_sum >= mod_ext) ? rhsp_pkg::hash_t'(seg_sum - mod_ext)
                                               : rhsp_pkg::hash_t'(seg_sum);

                cur_h_next = cur_h_reg;
                cur_p_next = cur_p_reg;
                priority if (cmd.out_load)
                begin
                    cur_h_next = '0;
                    cur_p_next = rhsp_pkg::hash_t'(1);
                end
                else if (cmd.load_write)
                begin
                    cur_h_next = new_h;
                    cur_p_next = mul_p_res;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cur_h_reg <= '0;
                    cur_p_reg <= rhsp_pkg::hash_t'(1);
                end
                else
                begin
                    cur_h_reg <= cur_h_next;
                    cur_p_reg <= cur_p_next;
                end
            end

            always_ff @(posedge clk)
            begin
                if (cmd.load_write)
                begin
                    hash_mem[waddr] <= new_h;
                    pow_mem[waddr]  <= mul_p_res;
                end
                hash_rd_reg <= hash_mem[rd_addr];
                pow_rd_reg  <= pow_mem[pw_addr];
            end

            always_ff @(posedge clk)
            begin
                if (cmd.cap_hi)
                begin
                    hold_hi_reg <= hash_rd_reg;
                end
                if (cmd.cap_len)
                begin
                    hold_len_reg <= hash_rd_reg;
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        p_next         = p_reg;
        lo_next        = lo_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load_write)
        begin
            count_next = waddr_full;
        end
        if (cmd.mark_ovf)
        begin
            ovf_next = 1'b1;
        end
        priority if (cmd.search_init)
        begin
            p_next  = CW'(1);
            lo_next = CW'(1);
        end
        else if (cmd.next_p)
        begin
            p_next  = p_reg + 1'b1;
            lo_next = CW'(1);
        end
        else if (cmd.seg_adv)
        begin
            lo_next = lo_reg + p_reg;
        end
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            count_next     = '0;
            ovf_next       = 1'b0;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            p_reg         <= CW'(1);
            lo_reg        <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            p_reg         <= p_next;
            lo_reg        <= lo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            code_reg <= char_code;
            last_reg <= last;
        end
        if (cmd.out_load)
        begin
            period_reg   <= rhsp_pkg::PERIOD_W'(p_reg);
            too_long_reg <= ovf_reg;
        end
        rd_zero_reg <= (rd_full == '0);
    end

    always_comb
    begin
        status.mul_busy  = (|lane_busy_h) | (|lane_busy_p);
        status.full      = (count_reg == CW'(MAX_LEN));
        status.last      = last_reg;
        status.seg_match = &lane_match;
        status.seg_final = ((lo_reg + p_reg) > count_reg);
        status.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign period   = period_reg;
    assign too_long = too_long_reg;

endmodule

>>> rtl/rolling_hash_string_period.sv
// ----------------------------------------------------------------------------
// rolling_hash_string_period
// Smallest period of a streamed string by triple-modulus rolling hash.
// ----------------------------------------------------------------------------
// Characters arrive one per request, the final one with tlast; up to MAX_LEN
// are kept and later ones are dropped and reported through m_tuser. Loading a
// character uses a 9-step bit-serial multiply by the base 311, and no new
// character is taken until it is written. After the final character the
// search tests candidate periods from 1 upward; each block compared uses the
// 30-step bit-serial modular multiplier, and a candidate costs the blocks up
// to and including its first mismatch, or ceil(n/p) blocks when it passes.
// One result request follows each string and is held in an output register,
// so loading the next string may begin while it waits.
module rolling_hash_string_period #(
    parameter int MAX_LEN = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [6:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [12:0] period
    output logic        m_tuser    // [0] too_long
);

    rhsp_pkg::rhsp_cmd_t            cmd;
    rhsp_pkg::rhsp_status_t         status;
    logic [rhsp_pkg::PERIOD_W-1:0]  period;

    rhsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rhsp_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .char_code (s_tdata[rhsp_pkg::CODE_W-1:0]),
        .last      (s_tlast),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .period    (period),
        .too_long  (m_tuser)
    );

    assign m_tdata = 16'(period);

endmodule
